/* rtl/bmhq_pkg.sv */
// shared types and codes for the max priority queue
package bmhq_pkg;

   // operation codes
   localparam logic KIND_INSERT = 1'b0;
   localparam logic KIND_REMOVE = 1'b1;

   // status codes
   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_FULL  = 2'd1;
   localparam logic [1:0] STATUS_EMPTY = 2'd2;

   // width of the reported entry count
   localparam int COUNT_OUT_W = 5;

   typedef logic signed [31:0] key_type;

   typedef struct packed {
      logic    kind;
      key_type value;
   } req_type;

   typedef struct packed {
      key_type                  removed_value;
      key_type                  top_value;
      logic [COUNT_OUT_W-1:0]   entry_count;
      logic [1:0]               status;
   } rsp_type;

   // command broadcast to every cell of the chain
   typedef struct packed {
      logic    ins;
      logic    rem;
      key_type key;
   } cell_ctrl_type;

endpackage

/* rtl/bmhq_cell.sv */
// one cell of the sorted key chain: holds one key, shifts with its neighbours
module bmhq_cell (
   input  logic                    clock,
   input  bmhq_pkg::cell_ctrl_type ctrl,
   input  logic                    occ,
   input  bmhq_pkg::key_type       prev_value,
   input  logic                    prev_gt,
   input  bmhq_pkg::key_type       next_value,
   output bmhq_pkg::key_type       value,
   output logic                    gt
);

   bmhq_pkg::key_type value_ff;
   bmhq_pkg::key_type value_in;

   // new key goes in front of this cell's key
   assign gt = !occ || (ctrl.key > value_ff);

   // insert: shift down from the upper neighbour or take the new key
   // remove: shift up from the lower neighbour
   always_comb begin
      value_in = value_ff;
      if (ctrl.ins) begin
         if (gt) begin
            value_in = prev_gt ? prev_value : ctrl.key;
         end
      end else if (ctrl.rem) begin
         value_in = next_value;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value = value_ff;

endmodule

/* rtl/binary_max_heap_queue.sv */
// max priority queue built as a sorted chain of key cells
//
//   channel | direction | payload            | handshake
//   req     | in        | kind, value        | req_valid / req_ready
//   rsp     | out       | removed, top, count, status | rsp_valid / rsp_ready
//
// every cell compares the beat's key in parallel with its own key and shifts
// by one place; the result appears in the output register in the cycle
// after acceptance.
// reset clears the entry count and the output valid; cell keys need no reset.
// req_ready stays high while the output register is empty or being taken.
module binary_max_heap_queue #(
   parameter int CAPACITY = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  bmhq_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output bmhq_pkg::rsp_type rsp_data
);

   // count width, never narrower than the reported count
   localparam int CNT_BITS = $clog2(CAPACITY + 1);
   localparam int CW       = (CNT_BITS > bmhq_pkg::COUNT_OUT_W) ? CNT_BITS
                                                                 : bmhq_pkg::COUNT_OUT_W;

   logic [CW-1:0]     count_ff;
   logic [CW-1:0]     count_in;
   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   bmhq_pkg::rsp_type rsp_data_ff;
   bmhq_pkg::rsp_type rsp_data_in;

   logic              fire;
   logic              full;
   logic              empty;
   logic              ins_ok;
   logic              rem_ok;

   bmhq_pkg::cell_ctrl_type ctrl;
   bmhq_pkg::key_type       cell_value [CAPACITY];
   logic                    cell_gt    [CAPACITY];

   // handshake and operation decode
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign fire      = req_valid && req_ready;
   assign full      = (count_ff == CW'(CAPACITY));
   assign empty     = (count_ff == '0);
   assign ins_ok    = fire && (req_data.kind == bmhq_pkg::KIND_INSERT) && !full;
   assign rem_ok    = fire && (req_data.kind == bmhq_pkg::KIND_REMOVE) && !empty;

   assign ctrl.ins = ins_ok;
   assign ctrl.rem = rem_ok;
   assign ctrl.key = req_data.value;

   // chain of cells, largest key at the head
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic occ;
      bmhq_pkg::key_type prev_v;
      logic prev_g;
      bmhq_pkg::key_type next_v;

      assign occ = (CW'(i) < count_ff);

      if (i == 0) begin : g_head
         assign prev_v = '0;
         assign prev_g = 1'b0;
      end else begin : g_mid
         assign prev_v = cell_value[i-1];
         assign prev_g = cell_gt[i-1];
      end

      if (i == CAPACITY - 1) begin : g_tail
         assign next_v = '0;
      end else begin : g_body
         assign next_v = cell_value[i+1];
      end

      bmhq_cell u_cell (
         .clock      (clock),
         .ctrl       (ctrl),
         .occ        (occ),
         .prev_value (prev_v),
         .prev_gt    (prev_g),
         .next_value (next_v),
         .value      (cell_value[i]),
         .gt         (cell_gt[i])
      );
   end

   // next count and response
   always_comb begin
      count_in    = count_ff;
      rsp_data_in = rsp_data_ff;
      if (fire) begin
         rsp_data_in.removed_value = '0;
         rsp_data_in.status        = bmhq_pkg::STATUS_OK;
         rsp_data_in.top_value     = empty ? '0 : cell_value[0];
         if (ins_ok) begin
            count_in = count_ff + CW'(1);
            if (empty || (req_data.value > cell_value[0])) begin
               rsp_data_in.top_value = req_data.value;
            end
         end else if (rem_ok) begin
            count_in = count_ff - CW'(1);
            rsp_data_in.removed_value = cell_value[0];
            rsp_data_in.top_value     = (count_ff > CW'(1)) ? cell_value[1] : '0;
         end else if (req_data.kind == bmhq_pkg::KIND_INSERT) begin
            rsp_data_in.status = bmhq_pkg::STATUS_FULL;
         end else begin
            rsp_data_in.status = bmhq_pkg::STATUS_EMPTY;
         end
         rsp_data_in.entry_count = count_in[bmhq_pkg::COUNT_OUT_W-1:0];
      end
   end

   // output register valid
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

/* bench/binary_max_heap_queue_tb.sv */
// self-checking bench for the max priority queue: queued driver, monitor and heap predictor
`timescale 1ns / 1ps

module binary_max_heap_queue_tb;

   localparam int CAPACITY       = 16;
   localparam int RANDOM_OPS     = 700;
   localparam int TIMEOUT_CYCLES = 200000;
   localparam int DRAIN_CYCLES   = 20;
   localparam int REPORT_LIMIT   = 10;

   logic              clock     = 1'b0;
   logic              reset     = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   bmhq_pkg::req_type req_data  = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   bmhq_pkg::rsp_type rsp_data;

   // operations waiting to be driven and results waiting to be seen
   bmhq_pkg::req_type queued_ops[$];
   bmhq_pkg::rsp_type expected_heap_results[$];

   // predictor copy of the heap
   bmhq_pkg::key_type heap_slots[CAPACITY];
   int                heap_fill = 0;

   int accepted_ops   = 0;
   int mismatch_count = 0;
   int cycle_count    = 0;

   binary_max_heap_queue #(
      .CAPACITY(CAPACITY)
   ) DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // clock and cycle count
   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   // apply one operation to the predictor heap and return the result it gives
   function automatic bmhq_pkg::rsp_type heap_apply(bmhq_pkg::req_type op);
      bmhq_pkg::rsp_type res;
      bmhq_pkg::key_type tmp;
      int      pos;
      int      parent;
      int      left;
      int      right;
      int      pick;
      res        = '0;
      res.status = bmhq_pkg::STATUS_OK;
      if (op.kind == bmhq_pkg::KIND_INSERT) begin
         if (heap_fill >= CAPACITY) begin
            res.status = bmhq_pkg::STATUS_FULL;
         end else begin
            heap_slots[heap_fill] = op.value;
            pos = heap_fill;
            heap_fill++;
            // sift up while the parent is strictly smaller
            while (pos > 0) begin
               parent = (pos - 1) / 2;
               if (!(heap_slots[parent] < heap_slots[pos])) break;
               tmp                = heap_slots[parent];
               heap_slots[parent] = heap_slots[pos];
               heap_slots[pos]    = tmp;
               pos                = parent;
            end
         end
      end else begin
         if (heap_fill == 0) begin
            res.status = bmhq_pkg::STATUS_EMPTY;
         end else begin
            res.removed_value = heap_slots[0];
            heap_fill--;
            heap_slots[0] = heap_slots[heap_fill];
            pos = 0;
            // sift down against the larger existing child, left on a tie
            forever begin
               left  = 2 * pos + 1;
               right = left + 1;
               if (left >= heap_fill) break;
               pick = left;
               if (right < heap_fill && heap_slots[left] < heap_slots[right]) pick = right;
               if (!(heap_slots[pos] < heap_slots[pick])) break;
               tmp              = heap_slots[pos];
               heap_slots[pos]  = heap_slots[pick];
               heap_slots[pick] = tmp;
               pos              = pick;
            end
         end
      end
      res.top_value   = (heap_fill > 0) ? heap_slots[0] : bmhq_pkg::key_type'(0);
      res.entry_count = bmhq_pkg::COUNT_OUT_W'(heap_fill);
      return res;
   endfunction

   // random stall, none during the calm stretch
   function automatic logic stall_now();
      if (accepted_ops >= 300 && accepted_ops < 450) return 1'b0;
      return ($urandom_range(0, 99) < 38);
   endfunction

   // keys biased towards extremes and small values so that ties happen
   function automatic bmhq_pkg::key_type draw_key();
      case ($urandom_range(0, 9))
         5, 6, 7: return bmhq_pkg::key_type'($urandom_range(0, 8) - 4);
         8:       return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
         9:       return $urandom_range(0, 1)
                     ? bmhq_pkg::key_type'(32'h7FFF_FFF0 + $urandom_range(0, 15))
                     : bmhq_pkg::key_type'(32'h8000_0000 + $urandom_range(0, 15));
         default: return bmhq_pkg::key_type'($urandom);
      endcase
   endfunction

   task automatic queue_op(logic kind, bmhq_pkg::key_type value);
      bmhq_pkg::req_type op;
      op.kind  = kind;
      op.value = value;
      queued_ops.push_back(op);
   endtask

   // driver: present queued beats, predict on every accepted one
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            expected_heap_results.push_back(heap_apply(req_data));
            accepted_ops <= accepted_ops + 1;
         end
         if (!req_valid || req_ready) begin
            if (queued_ops.size() > 0 && !stall_now()) begin
               req_valid <= 1'b1;
               req_data  <= queued_ops.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor: compare each result beat with the oldest expectation
   always @(posedge clock) begin
      bmhq_pkg::rsp_type exp_rsp;
      rsp_ready <= !stall_now();
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_heap_results.size() == 0) begin
            mismatch_count <= mismatch_count + 1;
            if (mismatch_count < REPORT_LIMIT)
               $display("unexpected result beat: removed=%0d top=%0d count=%0d status=%0d",
                        rsp_data.removed_value, rsp_data.top_value,
                        rsp_data.entry_count, rsp_data.status);
         end else begin
            exp_rsp = expected_heap_results.pop_front();
            if (rsp_data.removed_value !== exp_rsp.removed_value ||
                rsp_data.top_value     !== exp_rsp.top_value     ||
                rsp_data.entry_count   !== exp_rsp.entry_count   ||
                rsp_data.status        !== exp_rsp.status) begin
               mismatch_count <= mismatch_count + 1;
               if (mismatch_count < REPORT_LIMIT)
                  $display("mismatch: exp removed=%0d top=%0d count=%0d status=%0d,",
                           exp_rsp.removed_value, exp_rsp.top_value,
                           exp_rsp.entry_count, exp_rsp.status,
                           " got removed=%0d top=%0d count=%0d status=%0d",
                           rsp_data.removed_value, rsp_data.top_value,
                           rsp_data.entry_count, rsp_data.status);
            end
         end
      end
   end

   // watchdog
   initial begin
      while (cycle_count < TIMEOUT_CYCLES) @(posedge clock);
      $display("binary_max_heap_queue_tb NOT OK");
      $finish;
   end

   // stimulus and end of run
   initial begin
      int generated;
      int phase_len;
      int insert_pct;
      logic kind;

      // directed: remove on empty, fill with extremes and ties, insert on full
      queue_op(bmhq_pkg::KIND_REMOVE, bmhq_pkg::key_type'($urandom));
      queue_op(bmhq_pkg::KIND_INSERT, 32'sh8000_0000);
      queue_op(bmhq_pkg::KIND_INSERT, 32'sh7FFF_FFFF);
      queue_op(bmhq_pkg::KIND_INSERT, 32'sd0);
      queue_op(bmhq_pkg::KIND_INSERT, -32'sd1);
      queue_op(bmhq_pkg::KIND_INSERT, 32'sd5);
      queue_op(bmhq_pkg::KIND_INSERT, 32'sd5);
      queue_op(bmhq_pkg::KIND_INSERT, 32'sd5);
      queue_op(bmhq_pkg::KIND_INSERT, 32'sd1);
      queue_op(bmhq_pkg::KIND_INSERT, -32'sd2);
      queue_op(bmhq_pkg::KIND_INSERT, 32'sh7FFF_FFFF);
      queue_op(bmhq_pkg::KIND_INSERT, 32'sh8000_0000);
      queue_op(bmhq_pkg::KIND_INSERT, 32'sd3);
      queue_op(bmhq_pkg::KIND_INSERT, 32'sd9);
      queue_op(bmhq_pkg::KIND_INSERT, 32'sd2);
      queue_op(bmhq_pkg::KIND_INSERT, -32'sd7);
      queue_op(bmhq_pkg::KIND_INSERT, 32'sd4);
      queue_op(bmhq_pkg::KIND_INSERT, 32'sd11);
      queue_op(bmhq_pkg::KIND_REMOVE, 32'sh7FFF_FFFF);
      queue_op(bmhq_pkg::KIND_REMOVE, 32'sh8000_0000);
      queue_op(bmhq_pkg::KIND_REMOVE, 32'sd0);
      queue_op(bmhq_pkg::KIND_REMOVE, bmhq_pkg::key_type'($urandom));

      // random phases leaning to insert, to remove or balanced
      generated = 0;
      while (generated < RANDOM_OPS) begin
         case ($urandom_range(0, 2))
            0:       insert_pct = 85;
            1:       insert_pct = 15;
            default: insert_pct = 50;
         endcase
         phase_len = $urandom_range(20, 60);
         repeat (phase_len) begin
            kind = ($urandom_range(0, 99) < insert_pct) ? bmhq_pkg::KIND_INSERT
                                                        : bmhq_pkg::KIND_REMOVE;
            queue_op(kind, draw_key());
            generated++;
         end
      end

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      while (queued_ops.size() != 0 || req_valid) @(posedge clock);
      while (expected_heap_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0 && expected_heap_results.size() == 0) begin
         $display("binary_max_heap_queue_tb OK");
      end else begin
         $display("binary_max_heap_queue_tb NOT OK");
      end
      $finish;
   end

endmodule

/* sim.f */
rtl/bmhq_pkg.sv
rtl/bmhq_cell.sv
rtl/binary_max_heap_queue.sv
bench/binary_max_heap_queue_tb.sv
